// ===== rtl/rrps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_pkg: shared types and constants of the round-robin process scheduler
// Operation, process state and status codes, table and queue control bundles.
// ----------------------------------------------------------------------------
package rrps_pkg;

    localparam int MAX_PROCS = 64;
    localparam int SLOT_W    = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int ALIVE_W   = 7;
    localparam int QUANT_W   = 16;
    localparam int EV_W      = 3;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd1024;
    localparam logic [ALIVE_W-1:0] ALIVE_MAX     = 7'd127;

    typedef enum logic [2:0] {
        OP_SPAWN    = 3'd0,
        OP_READY    = 3'd1,
        OP_KILL     = 3'd2,
        OP_DISPATCH = 3'd3,
        OP_RETIRE   = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_READY   = 4'd0,
        ST_RUNNING = 4'd1,
        ST_BLOCKED = 4'd2,
        ST_DEAD    = 4'd3,
        ST_DECODE  = 4'd4,
        ST_EXECUTE = 4'd5,
        ST_WAITIO  = 4'd6,
        ST_HALT    = 4'd7,
        ST_NEW     = 4'd8
    } proc_state_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_FULL    = 3'd1,
        STS_UNKNOWN = 3'd2,
        STS_EMPTY   = 3'd3,
        STS_QFULL   = 3'd4,
        STS_IDLE    = 3'd5
    } status_t;

    typedef enum logic [EV_W-1:0] {
        EV_DONE   = 3'd0,
        EV_IOWAIT = 3'd1,
        EV_HALT   = 3'd2,
        EV_ERROR  = 3'd3,
        EV_YIELD  = 3'd4
    } exec_event_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        proc_state_t       data;
        logic              used_we;
        logic              used_val;
    } slot_wr_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [SLOT_W-1:0] push_data;
    } queue_ctl_t;

    function automatic proc_state_t exec_next(input logic [EV_W-1:0] ev);
        proc_state_t ns;
        case (ev)
            EV_DONE:   ns = ST_DECODE;
            EV_IOWAIT: ns = ST_WAITIO;
            EV_HALT:   ns = ST_HALT;
            EV_ERROR:  ns = ST_DEAD;
            EV_YIELD:  ns = ST_READY;
            default:   ns = ST_EXECUTE;
        endcase
        return ns;
    endfunction

endpackage

// ===== rtl/round_robin_process_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_process_scheduler: round-robin scheduler with a time quantum
// Process table, ready queue, running process, quantum and alive count.
// ----------------------------------------------------------------------------
// One operation is accepted every clock cycle unless the input side stalls,
// and its result beat is presented from the result register: acceptance
// loads the input register and the registered reads of the slot state
// memory and the queue head, and firing the operation loads the result register.
// The input side stalls only while a result beat waits in the result register
// and the downstream side is not ready. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module round_robin_process_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] target_pid, [8:6] exec_event, [15:9] zero.
    input  logic [15:0] s_tdata,
    // [2:0] operation.
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] result_pid, [6] pid_valid, [10:7] proc_state, [17:11] live_count,
    // [33:18] quantum_left, [36:34] status, [39:37] zero.
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                          in_vld_reg;
    rrps_pkg::op_t                 op_reg;
    logic [rrps_pkg::SLOT_W-1:0]   tgt_reg;
    logic [rrps_pkg::EV_W-1:0]     ev_reg;
    logic                          fire, s_accept;

    logic [rrps_pkg::QUANT_W-1:0]  qlen_reg;
    logic                          run_vld_reg, run_vld_next;
    logic [rrps_pkg::SLOT_W-1:0]   run_slot_reg, run_slot_next;
    logic [rrps_pkg::QUANT_W-1:0]  quant_reg, quant_next;
    logic [rrps_pkg::ALIVE_W-1:0]  alive_reg, alive_next;

    logic                          m_tvalid_reg;
    logic [39:0]                   m_tdata_reg;

    rrps_pkg::slot_wr_t            swr;
    rrps_pkg::queue_ctl_t          qctl;
    rrps_pkg::proc_state_t         tgt_state;
    logic [rrps_pkg::MAX_PROCS-1:0] used_vec, new_vec;
    logic                          free_any;
    logic [rrps_pkg::SLOT_W-1:0]   free_idx;
    logic [rrps_pkg::SLOT_W-1:0]   head_data;
    logic [rrps_pkg::CNT_W-1:0]    q_count;
    logic                          q_full, q_empty;

    logic [rrps_pkg::SLOT_W-1:0]   res_pid;
    logic                          res_valid;
    rrps_pkg::proc_state_t         res_state;
    rrps_pkg::status_t             res_status;
    rrps_pkg::proc_state_t         ns;
    logic [rrps_pkg::QUANT_W-1:0]  quant_dec;
    logic                          dead_class;

    assign fire      = in_vld_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !in_vld_reg || fire;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= rrps_pkg::op_t'(s_tuser);
            tgt_reg <= s_tdata[5:0];
            ev_reg  <= s_tdata[8:6];
        end
    end

    rrps_slot_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (s_tdata[5:0]),
        .rd_state (tgt_state),
        .wr       (swr),
        .used_vec (used_vec),
        .new_vec  (new_vec),
        .free_any (free_any),
        .free_idx (free_idx)
    );

    rrps_ready_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (qctl),
        .head_data (head_data),
        .count     (q_count),
        .full      (q_full),
        .empty     (q_empty)
    );

    always_comb begin
        res_pid       = '0;
        res_valid     = 1'b0;
        res_state     = rrps_pkg::ST_READY;
        res_status    = rrps_pkg::STS_OK;
        alive_next    = alive_reg;
        quant_next    = quant_reg;
        run_vld_next  = run_vld_reg;
        run_slot_next = run_slot_reg;
        swr           = '0;
        qctl          = '0;
        ns            = rrps_pkg::exec_next(ev_reg);
        quant_dec     = (quant_reg != '0) ? quant_reg - 1'b1 : quant_reg;
        dead_class    = tgt_state inside {rrps_pkg::ST_NEW, rrps_pkg::ST_HALT,
                                          rrps_pkg::ST_DEAD};
        if ((ns inside {rrps_pkg::ST_DECODE, rrps_pkg::ST_EXECUTE}) &&
            (quant_dec == '0)) begin
            ns = rrps_pkg::ST_READY;
        end
        if (fire) begin
            case (op_reg)
                rrps_pkg::OP_SPAWN: begin
                    res_status = rrps_pkg::STS_FULL;
                    if (free_any) begin
                        swr.we       = 1'b1;
                        swr.addr     = free_idx;
                        swr.data     = rrps_pkg::ST_NEW;
                        swr.used_we  = 1'b1;
                        swr.used_val = 1'b1;
                        res_pid      = free_idx;
                        res_valid    = 1'b1;
                        res_state    = rrps_pkg::ST_NEW;
                        res_status   = rrps_pkg::STS_OK;
                    end
                end
                rrps_pkg::OP_READY, rrps_pkg::OP_KILL: begin
                    res_pid = tgt_reg;
                    if (!used_vec[tgt_reg]) begin
                        res_status = rrps_pkg::STS_UNKNOWN;
                    end else if (op_reg == rrps_pkg::OP_READY && q_full) begin
                        res_valid  = 1'b1;
                        res_status = rrps_pkg::STS_QFULL;
                        res_state  = tgt_state;
                    end else begin
                        swr.addr = tgt_reg;
                        swr.we   = 1'b1;
                        if (run_vld_reg && (run_slot_reg == tgt_reg)) begin
                            run_vld_next = 1'b0;
                        end
                        if (op_reg == rrps_pkg::OP_READY) begin
                            qctl.push      = 1'b1;
                            qctl.push_data = tgt_reg;
                            if (dead_class && (alive_reg != rrps_pkg::ALIVE_MAX)) begin
                                alive_next = alive_reg + 1'b1;
                            end
                            swr.data  = rrps_pkg::ST_READY;
                            res_valid = 1'b1;
                            res_state = rrps_pkg::ST_READY;
                        end else begin
                            if (!dead_class && (alive_reg != '0)) begin
                                alive_next = alive_reg - 1'b1;
                            end
                            swr.data     = rrps_pkg::ST_DEAD;
                            swr.used_we  = 1'b1;
                            swr.used_val = 1'b0;
                            res_state    = rrps_pkg::ST_DEAD;
                        end
                    end
                end
                rrps_pkg::OP_DISPATCH: begin
                    run_vld_next = 1'b0;
                    if (q_empty) begin
                        res_status = rrps_pkg::STS_EMPTY;
                    end else begin
                        qctl.pop = 1'b1;
                        res_pid  = head_data;
                        if (!used_vec[head_data] || new_vec[head_data]) begin
                            res_state = rrps_pkg::ST_DEAD;
                        end else begin
                            swr.we        = 1'b1;
                            swr.addr      = head_data;
                            swr.data      = rrps_pkg::ST_DECODE;
                            run_slot_next = head_data;
                            run_vld_next  = 1'b1;
                            quant_next    = qlen_reg;
                            res_valid     = 1'b1;
                            res_state     = rrps_pkg::ST_DECODE;
                        end
                    end
                end
                rrps_pkg::OP_RETIRE: begin
                    if (!run_vld_reg) begin
                        res_status = rrps_pkg::STS_IDLE;
                    end else begin
                        quant_next = quant_dec;
                        case (ns)
                            rrps_pkg::ST_HALT, rrps_pkg::ST_DEAD: begin
                                run_vld_next = 1'b0;
                                if (alive_reg != '0) begin
                                    alive_next = alive_reg - 1'b1;
                                end
                            end
                            rrps_pkg::ST_WAITIO: begin
                                run_vld_next = 1'b0;
                            end
                            rrps_pkg::ST_READY: begin
                                run_vld_next = 1'b0;
                                if (q_full) begin
                                    res_status = rrps_pkg::STS_QFULL;
                                end else begin
                                    qctl.push      = 1'b1;
                                    qctl.push_data = run_slot_reg;
                                end
                            end
                            default: begin
                            end
                        endcase
                        swr.we    = 1'b1;
                        swr.addr  = run_slot_reg;
                        swr.data  = ns;
                        res_pid   = run_slot_reg;
                        res_valid = 1'b1;
                        res_state = ns;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlen_reg     <= rrps_pkg::QUANTUM_RESET;
            run_vld_reg  <= 1'b0;
            run_slot_reg <= '0;
            quant_reg    <= '0;
            alive_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                qlen_reg <= cfg_data;
            end
            run_vld_reg  <= run_vld_next;
            run_slot_reg <= run_slot_next;
            quant_reg    <= quant_next;
            alive_reg    <= alive_next;
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {3'b000, res_status, quant_next, alive_next,
                            res_state, res_valid, res_pid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= rrps_pkg::CNT_W'(rrps_pkg::MAX_PROCS))
        else $error("Ready queue count exceeds its depth.");

    a_dispatch_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (op_reg == rrps_pkg::OP_DISPATCH) && res_valid |=> run_vld_reg)
        else $error("A valid dispatch did not leave a running process.");

    a_retire_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (op_reg == rrps_pkg::OP_RETIRE) && !run_vld_reg |=>
        m_tvalid && (m_tdata[36:34] == rrps_pkg::STS_IDLE))
        else $error("Retire with nothing running did not report idle.");

    a_no_push_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qctl.push && qctl.pop))
        else $error("Ready queue pushed and popped in the same cycle.");

endmodule

// ===== rtl/rrps_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_slot_table: process slot table
// Used and new flags per slot, a state memory with one registered read port
// that forwards a same-cycle write, and the lowest free slot search.
// ----------------------------------------------------------------------------
module rrps_slot_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rd_en,
    input  logic [rrps_pkg::SLOT_W-1:0]         rd_addr,
    output rrps_pkg::proc_state_t               rd_state,
    input  rrps_pkg::slot_wr_t                  wr,
    output logic [rrps_pkg::MAX_PROCS-1:0]      used_vec,
    output logic [rrps_pkg::MAX_PROCS-1:0]      new_vec,
    output logic                                free_any,
    output logic [rrps_pkg::SLOT_W-1:0]         free_idx
);

    rrps_pkg::proc_state_t state_mem [rrps_pkg::MAX_PROCS];
    rrps_pkg::proc_state_t rd_state_reg;
    logic [rrps_pkg::MAX_PROCS-1:0] used_reg;
    logic [rrps_pkg::MAX_PROCS-1:0] new_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            state_mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            if (wr.we && (wr.addr == rd_addr)) begin
                rd_state_reg <= wr.data;
            end else begin
                rd_state_reg <= state_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            new_reg  <= '0;
        end else begin
            if (wr.used_we) begin
                used_reg[wr.addr] <= wr.used_val;
            end
            if (wr.we) begin
                new_reg[wr.addr] <= (wr.data == rrps_pkg::ST_NEW);
            end
        end
    end

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = rrps_pkg::MAX_PROCS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_any = 1'b1;
                free_idx = rrps_pkg::SLOT_W'(i);
            end
        end
    end

    assign rd_state = rd_state_reg;
    assign used_vec = used_reg;
    assign new_vec  = new_reg;

endmodule

// ===== rtl/rrps_ready_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_ready_queue: FIFO of ready slot numbers
// Circular buffer memory with head, tail and count; the head entry is
// prefetched into a register so a pop sees it without a read delay.
// ----------------------------------------------------------------------------
module rrps_ready_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rrps_pkg::queue_ctl_t            ctl,
    output logic [rrps_pkg::SLOT_W-1:0]     head_data,
    output logic [rrps_pkg::CNT_W-1:0]      count,
    output logic                            full,
    output logic                            empty
);

    logic [rrps_pkg::SLOT_W-1:0] fifo_mem [rrps_pkg::MAX_PROCS];
    logic [rrps_pkg::SLOT_W-1:0] head_reg, head_next;
    logic [rrps_pkg::SLOT_W-1:0] tail_reg, tail_next;
    logic [rrps_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [rrps_pkg::SLOT_W-1:0] head_data_reg;

    localparam logic [rrps_pkg::SLOT_W-1:0] LAST_IDX =
        rrps_pkg::SLOT_W'(rrps_pkg::MAX_PROCS - 1);
    localparam logic [rrps_pkg::CNT_W-1:0] DEPTH =
        rrps_pkg::CNT_W'(rrps_pkg::MAX_PROCS);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.push) begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (ctl.pop) begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            fifo_mem[tail_reg] <= ctl.push_data;
        end
        if (ctl.push && (tail_reg == head_next)) begin
            head_data_reg <= ctl.push_data;
        end else begin
            head_data_reg <= fifo_mem[head_next];
        end
    end

    assign head_data = head_data_reg;
    assign count     = count_reg;
    assign full      = (count_reg == DEPTH);
    assign empty     = (count_reg == '0);

endmodule
